### rtl/json_string_unescape_unit_macros.svh
// assertion helpers shared by the unescape unit
`ifndef JSON_STRING_UNESCAPE_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/jsu_pkg.sv
package jsu_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    localparam logic [7:0] CTRL_BS = 8'h08;
    localparam logic [7:0] CTRL_FF = 8'h0C;
    localparam logic [7:0] CTRL_LF = 8'h0A;
    localparam logic [7:0] CTRL_CR = 8'h0D;
    localparam logic [7:0] CTRL_HT = 8'h09;

    localparam logic [7:0]  UTF_LEAD2      = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3      = 8'hE0;
    localparam logic [7:0]  UTF_CONT       = 8'h80;
    localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NO_QUOTE = 3'd1,
        ERR_BAD_ESC  = 3'd2,
        ERR_BAD_HEX  = 3'd3,
        ERR_UNTERM   = 3'd4
    } err_code_t;

    typedef enum logic [2:0] {
        CMD_BYTE,
        CMD_UTF2,
        CMD_UTF3,
        CMD_FINISH,
        CMD_ERROR
    } cmd_kind_t;

    // one queued job: a plain byte, a code point to expand, a finish or an error
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] value;
        err_code_t   err;
    } cmd_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       finished;
        err_code_t  error_code;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic beat_t make_beat(cmd_t cmd, logic [1:0] idx);
        beat_t b;
        b = '0;
        b.error_code = ERR_NONE;
        unique case (cmd.kind)
            CMD_BYTE:
            begin
                b.data_byte  = cmd.value[7:0];
                b.data_valid = 1'b1;
                b.last       = 1'b1;
            end
            CMD_UTF2:
            begin
                b.data_valid = 1'b1;
                if (idx == 2'd0)
                begin
                    b.data_byte = UTF_LEAD2 | {3'b000, cmd.value[10:6]};
                end
                else
                begin
                    b.data_byte = UTF_CONT | {2'b00, cmd.value[5:0]};
                    b.last      = 1'b1;
                end
            end
            CMD_UTF3:
            begin
                b.data_valid = 1'b1;
                if (idx == 2'd0)
                begin
                    b.data_byte = UTF_LEAD3 | {4'b0000, cmd.value[15:12]};
                end
                else if (idx == 2'd1)
                begin
                    b.data_byte = UTF_CONT | {2'b00, cmd.value[11:6]};
                end
                else
                begin
                    b.data_byte = UTF_CONT | {2'b00, cmd.value[5:0]};
                    b.last      = 1'b1;
                end
            end
            CMD_FINISH:
            begin
                b.finished = 1'b1;
                b.last     = 1'b1;
            end
            CMD_ERROR:
            begin
                b.error_code = cmd.err;
                b.last       = 1'b1;
            end
            default:
            begin
                b.last = 1'b1;
            end
        endcase
        return b;
    endfunction

endpackage

### rtl/json_string_unescape_unit.sv
// Unescapes a JSON string literal arriving one source byte per beat, opening quote
// first, and sends the decoded UTF-8 bytes out one per beat. A \u escape yields one to
// three bytes, a closing quote yields a finished beat and a fault yields one error beat;
// the opening quote, a backslash, the letter u and the first three hex digits yield
// nothing. The decoder takes one byte every cycle while its job queue (DEPTH entries)
// has room; the output side sends one beat per cycle while the sink is ready, and the
// queue soaks up the extra beats of a \u escape. A result passes through a queue entry
// and then the output register.
`include "json_string_unescape_unit_macros.svh"

module json_string_unescape_unit
    import jsu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // data_byte
    output logic [4:0] m_tuser,   // data_valid, finished, error_code[2:0]
    output logic       m_tlast
);

    logic      accept;
    logic      push;
    cmd_t      push_cmd;
    cmd_t      head;
    logic      pop;
    q_status_t q_stat;
    beat_t     out_beat;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    jsu_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_tdata),
        .push    (push),
        .cmd     (push_cmd)
    );

    jsu_queue #(.DEPTH(DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_stat)
    );

    jsu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_stat.empty),
        .pop       (pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_beat  (out_beat)
    );

    assign m_tdata = out_beat.data_byte;
    assign m_tuser = {out_beat.error_code, out_beat.finished, out_beat.data_valid};
    assign m_tlast = out_beat.last;

    `JSU_ASSERT_NOW(a_queue_flags, 1'b1, !(q_stat.full && q_stat.empty), "queue full and empty")
    `JSU_ASSERT_NOW(a_status_last, m_tvalid && !out_beat.data_valid, out_beat.last,
                    "status beat not marked last")
    `JSU_ASSERT_NOW(a_one_status, m_tvalid,
                    !(out_beat.finished && out_beat.error_code != ERR_NONE) &&
                    !(out_beat.data_valid && out_beat.error_code != ERR_NONE),
                    "beat mixes data, finish and error")
    `JSU_ASSERT_NEXT(a_full_push, q_stat.full && !pop, !push, "push into full queue")

endmodule

### rtl/jsu_front.sv
module jsu_front
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output logic       push,
    output cmd_t       cmd
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] cp_reg, cp_next;

    logic        esc_ok;
    logic [7:0]  esc_byte;
    logic        hex_ok;
    logic [3:0]  hex_digit;
    logic [15:0] cp_shift;

    always_comb
    begin
        esc_ok   = 1'b1;
        esc_byte = in_byte;
        unique case (in_byte) inside
            CH_QUOTE, CH_BSLASH, CH_SLASH: esc_byte = in_byte;
            CH_B:    esc_byte = CTRL_BS;
            CH_F:    esc_byte = CTRL_FF;
            CH_N:    esc_byte = CTRL_LF;
            CH_R:    esc_byte = CTRL_CR;
            CH_T:    esc_byte = CTRL_HT;
            default: esc_ok   = 1'b0;
        endcase
    end

    always_comb
    begin
        hex_ok    = 1'b1;
        hex_digit = 4'd0;
        if (in_byte >= CH_0 && in_byte <= CH_9)
        begin
            hex_digit = in_byte[3:0];
        end
        else if ((in_byte >= CH_LA && in_byte <= CH_LF) ||
                 (in_byte >= CH_UA && in_byte <= CH_UF))
        begin
            // letters a-f and A-F share their low nibble pattern: 1..6
            hex_digit = in_byte[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign cp_shift = {cp_reg[11:0], hex_digit};

    always_comb
    begin
        phase_next     = phase_reg;
        hex_count_next = hex_count_reg;
        cp_next        = cp_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (in_byte == CH_QUOTE)
                    begin
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (in_byte == CH_NUL || in_byte == CH_QUOTE)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (in_byte == CH_BSLASH)
                    begin
                        phase_next = PH_ESC;
                    end
                end
                PH_ESC:
                begin
                    if (in_byte == CH_NUL)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (esc_ok)
                    begin
                        phase_next = PH_BODY;
                    end
                    else if (in_byte == CH_U)
                    begin
                        phase_next     = PH_HEX;
                        hex_count_next = 2'd0;
                        cp_next        = 16'd0;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_HEX:
                begin
                    if (in_byte == CH_NUL || !hex_ok)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        cp_next = cp_shift;
                        if (hex_count_reg == 2'd3)
                        begin
                            hex_count_next = 2'd0;
                            phase_next     = PH_BODY;
                        end
                        else
                        begin
                            hex_count_next = hex_count_reg + 2'd1;
                        end
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    always_comb
    begin
        push       = 1'b0;
        cmd.kind   = CMD_BYTE;
        cmd.value  = {8'd0, in_byte};
        cmd.err    = ERR_NONE;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_byte != CH_QUOTE)
                begin
                    push     = 1'b1;
                    cmd.kind = CMD_ERROR;
                    cmd.err  = ERR_NO_QUOTE;
                end
            end
            PH_BODY:
            begin
                if (in_byte == CH_NUL)
                begin
                    push     = 1'b1;
                    cmd.kind = CMD_ERROR;
                    cmd.err  = ERR_UNTERM;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    push     = 1'b1;
                    cmd.kind = CMD_FINISH;
                end
                else if (in_byte != CH_BSLASH)
                begin
                    push = 1'b1;
                end
            end
            PH_ESC:
            begin
                if (in_byte == CH_NUL)
                begin
                    push     = 1'b1;
                    cmd.kind = CMD_ERROR;
                    cmd.err  = ERR_UNTERM;
                end
                else if (esc_ok)
                begin
                    push      = 1'b1;
                    cmd.value = {8'd0, esc_byte};
                end
                else if (in_byte != CH_U)
                begin
                    push     = 1'b1;
                    cmd.kind = CMD_ERROR;
                    cmd.err  = ERR_BAD_ESC;
                end
            end
            PH_HEX:
            begin
                if (in_byte == CH_NUL)
                begin
                    push     = 1'b1;
                    cmd.kind = CMD_ERROR;
                    cmd.err  = ERR_UNTERM;
                end
                else if (!hex_ok)
                begin
                    push     = 1'b1;
                    cmd.kind = CMD_ERROR;
                    cmd.err  = ERR_BAD_HEX;
                end
                else if (hex_count_reg == 2'd3)
                begin
                    push      = 1'b1;
                    cmd.value = cp_shift;
                    if (cp_shift < ONE_BYTE_LIMIT)
                    begin
                        cmd.kind = CMD_BYTE;
                    end
                    else if (cp_shift < TWO_BYTE_LIMIT)
                    begin
                        cmd.kind = CMD_UTF2;
                    end
                    else
                    begin
                        cmd.kind = CMD_UTF3;
                    end
                end
            end
            default: push = 1'b0;
        endcase
        push = push & accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hex_count_reg <= 2'd0;
            cp_reg        <= 16'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hex_count_reg <= hex_count_next;
            cp_reg        <= cp_next;
        end
    end

endmodule

### rtl/jsu_queue.sv
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/jsu_back.sv
module jsu_back
    import jsu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  head,
    input  logic  empty,
    output logic  pop,
    input  logic  out_ready,
    output logic  out_valid,
    output beat_t out_beat
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    beat_t      out_beat_reg;
    beat_t      beat;
    logic       load;
    logic       take;

    assign beat = make_beat(head, idx_reg);
    // output register frees up when empty or when its beat leaves this cycle
    assign load = !out_valid_reg || out_ready;
    assign take = load && !empty;
    assign pop  = take && beat.last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            idx_next       = beat.last ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (load)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_beat_reg <= beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

endmodule
